@@ rtl/tsft_pkg.sv @@
package tsft_pkg;

    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int DEPTH   = BUCKETS * WAYS;

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    localparam int SUM_W = 32;

    // reciprocal for the bucket remainder when BUCKETS is not a power of two:
    // floor(2^32 * (2^BKT_W - BUCKETS) / BUCKETS) + 1
    localparam logic [SUM_W-1:0] RECIP_M = SUM_W'((64'd1 << 32)
        * 64'((1 << BKT_W) - BUCKETS) / 64'(BUCKETS) + 64'd1);

    localparam int OUT_BKT_W = 10;

    // flag byte bit positions
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_BASE,
        S_RD,
        S_CMP,
        S_UPD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_QUO,
        H_REM
    } t_hash_state;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_IGNORE
    } t_op;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_TRACKED   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_UNTRACKED = 3'd3,
        ST_FULL      = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_SAME = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } t_hash_rsp;

endpackage

@@ rtl/tsft_bucket_hash.sv @@
module tsft_bucket_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_src_addr,
    input  logic [31:0]           i_dst_addr,
    input  logic [15:0]           i_source_port,
    input  logic [15:0]           i_dst_port,
    output tsft_pkg::t_hash_rsp   o_rsp
);

    localparam int BW = tsft_pkg::BKT_W;
    localparam int SW = tsft_pkg::SUM_W;

    tsft_pkg::t_hash_state r_state, n_state;
    logic [SW-1:0]              r_sum, n_sum;
    logic [SW-1:0]              r_acc, n_acc;
    logic [BW-1:0]              r_rem, n_rem;
    logic                       r_done, n_done;

    logic [SW-1:0]              sum;
    logic [2*SW-1:0]            prod;
    logic [SW-1:0]              quo;
    logic [SW-1:0]              rem;

    assign sum = i_src_addr + i_dst_addr
               + SW'(i_source_port) + SW'(i_dst_port);

    // remainder by a constant: high word of sum * reciprocal, fix-up add and shift
    // give the quotient, then subtract quotient * BUCKETS
    assign prod = (2*SW)'(r_sum) * (2*SW)'(tsft_pkg::RECIP_M);
    assign quo  = (r_acc + ((r_sum - r_acc) >> 1)) >> (BW - 1);
    assign rem  = r_sum - r_acc * SW'(tsft_pkg::BUCKETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsft_pkg::H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_sum <= n_sum;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_done  = 1'b0;
        unique case (r_state)
            tsft_pkg::H_IDLE: begin
                if (i_start) begin
                    if (tsft_pkg::BKT_POW2) begin
                        n_rem  = BW'(sum & SW'(tsft_pkg::BUCKETS - 1));
                        n_done = 1'b1;
                    end else begin
                        n_sum   = sum;
                        n_state = tsft_pkg::H_MUL;
                    end
                end
            end
            tsft_pkg::H_MUL: begin
                n_acc   = prod[2*SW-1:SW];
                n_state = tsft_pkg::H_QUO;
            end
            tsft_pkg::H_QUO: begin
                n_acc   = quo;
                n_state = tsft_pkg::H_REM;
            end
            tsft_pkg::H_REM: begin
                n_rem   = BW'(rem);
                n_done  = 1'b1;
                n_state = tsft_pkg::H_IDLE;
            end
            default: begin
                n_state = tsft_pkg::H_IDLE;
            end
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.bucket = r_rem;

endmodule

@@ rtl/tcp_syn_flow_table_unit.sv @@
// Channel  | Handshake                 | Beat contents
// ---------+---------------------------+---------------------------------------------
// input    | i_in_valid / o_in_ready   | addresses, ports, tcp flags, arrival time
// output   | o_out_valid / i_out_ready | status, direction, stored time, bucket, refused
//
// Sequence from the accept edge to o_in_ready again: hash, base, read and compare per way,
// update, final step; a match ends the scan early, an ignored packet skips it, and a
// bucket count that is not a power of two adds the multiply, quotient and remainder hash steps.
// Reset: a clearing pass writes every entry invalid while o_in_ready is low.
// Stalls: a result that is not taken holds the block in its final step; the next packet
// is accepted as soon as that result moves to the output register.
module tcp_syn_flow_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_tcp_flags,
    input  logic [31:0] i_arrival_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [1:0]  o_direction,
    output logic [31:0] o_stored_time,
    output logic [9:0]  o_bucket,
    output logic [31:0] o_refused_total
);

    localparam int AW = tsft_pkg::ADDR_W;
    localparam int WW = tsft_pkg::WAY_W;
    localparam int BW = tsft_pkg::BKT_W;

    // sequencer state
    tsft_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [WW-1:0]     r_way, n_way;
    logic [AW-1:0]     r_base, n_base;
    logic [BW-1:0]     r_bucket, n_bucket;

    // captured packet
    logic [31:0]       r_sa, n_sa;
    logic [31:0]       r_da, n_da;
    logic [15:0]       r_sp, n_sp;
    logic [15:0]       r_dp, n_dp;
    logic [31:0]       r_tm, n_tm;
    tsft_pkg::t_op     r_op, n_op;

    // scan results
    logic              r_found, n_found;
    tsft_pkg::t_dir    r_dir, n_dir;
    logic [WW-1:0]     r_hit_way, n_hit_way;
    logic [31:0]       r_time, n_time;
    logic              r_free_found, n_free_found;
    logic [WW-1:0]     r_free_way, n_free_way;
    tsft_pkg::t_status r_res_status, n_res_status;
    logic [31:0]       r_refused, n_refused;

    // output register
    logic              r_o_valid, n_o_valid;
    tsft_pkg::t_status r_o_status, n_o_status;
    tsft_pkg::t_dir    r_o_dir, n_o_dir;
    logic [31:0]       r_o_time, n_o_time;
    logic [9:0]        r_o_bucket, n_o_bucket;
    logic [31:0]       r_o_refused, n_o_refused;

    // entry memory
    tsft_pkg::t_entry  r_mem [tsft_pkg::DEPTH];
    tsft_pkg::t_entry  r_rd;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    tsft_pkg::t_entry  mem_wdata;

    logic                 in_acc;
    logic                 hash_start;
    tsft_pkg::t_hash_rsp  hash_rsp;
    logic                 hit_fwd;
    logic                 hit_rev;
    logic [WW-1:0]        wr_way;

    assign o_in_ready = (r_state == tsft_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign hash_start = in_acc;

    tsft_bucket_hash u_hash (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (hash_start),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_source_port (i_source_port),
        .i_dst_port    (i_dst_port),
        .o_rsp         (hash_rsp)
    );

    // compare the way just read against both directions of the flow
    assign hit_fwd = r_rd.valid && (r_rd.addrs == {r_sa, r_da}) && (r_rd.ports == {r_sp, r_dp});
    assign hit_rev = r_rd.valid && (r_rd.addrs == {r_da, r_sa}) && (r_rd.ports == {r_dp, r_sp});

    assign wr_way = (r_op == tsft_pkg::OP_INSERT) ? r_free_way : r_hit_way;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsft_pkg::S_CLEAR;
            r_clr     <= '0;
            r_refused <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_refused <= n_refused;
            r_o_valid <= n_o_valid;
        end
        r_way        <= n_way;
        r_base       <= n_base;
        r_bucket     <= n_bucket;
        r_sa         <= n_sa;
        r_da         <= n_da;
        r_sp         <= n_sp;
        r_dp         <= n_dp;
        r_tm         <= n_tm;
        r_op         <= n_op;
        r_found      <= n_found;
        r_dir        <= n_dir;
        r_hit_way    <= n_hit_way;
        r_time       <= n_time;
        r_free_found <= n_free_found;
        r_free_way   <= n_free_way;
        r_res_status <= n_res_status;
        r_o_status   <= n_o_status;
        r_o_dir      <= n_o_dir;
        r_o_time     <= n_o_time;
        r_o_bucket   <= n_o_bucket;
        r_o_refused  <= n_o_refused;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_way        = r_way;
        n_base       = r_base;
        n_bucket     = r_bucket;
        n_sa         = r_sa;
        n_da         = r_da;
        n_sp         = r_sp;
        n_dp         = r_dp;
        n_tm         = r_tm;
        n_op         = r_op;
        n_found      = r_found;
        n_dir        = r_dir;
        n_hit_way    = r_hit_way;
        n_time       = r_time;
        n_free_found = r_free_found;
        n_free_way   = r_free_way;
        n_res_status = r_res_status;
        n_refused    = r_refused;
        n_o_status   = r_o_status;
        n_o_dir      = r_o_dir;
        n_o_time     = r_o_time;
        n_o_bucket   = r_o_bucket;
        n_o_refused  = r_o_refused;
        n_o_valid    = r_o_valid && !i_out_ready;

        mem_we    = 1'b0;
        mem_addr  = r_base + AW'(r_way);
        mem_wdata = '0;

        unique case (r_state)
            tsft_pkg::S_CLEAR: begin
                // sweep every entry to invalid
                mem_we   = 1'b1;
                mem_addr = r_clr;
                if (r_clr == AW'(tsft_pkg::DEPTH - 1)) begin
                    n_state = tsft_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            tsft_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_sa         = i_src_addr;
                    n_da         = i_dst_addr;
                    n_sp         = i_source_port;
                    n_dp         = i_dst_port;
                    n_tm         = i_arrival_time;
                    n_way        = '0;
                    n_found      = 1'b0;
                    n_dir        = tsft_pkg::DIR_NONE;
                    n_time       = '0;
                    n_free_found = 1'b0;
                    n_free_way   = '0;
                    n_hit_way    = '0;
                    // SYN without ACK inserts whatever RST says
                    if (i_tcp_flags[tsft_pkg::FLAG_SYN]
                        && !i_tcp_flags[tsft_pkg::FLAG_ACK]) begin
                        n_op = tsft_pkg::OP_INSERT;
                    end else if (i_tcp_flags[tsft_pkg::FLAG_SYN]
                                 || i_tcp_flags[tsft_pkg::FLAG_RST]) begin
                        n_op = tsft_pkg::OP_REMOVE;
                    end else begin
                        n_op = tsft_pkg::OP_IGNORE;
                    end
                    n_state = tsft_pkg::S_HASH;
                end
            end
            tsft_pkg::S_HASH: begin
                if (hash_rsp.done) begin
                    n_bucket = hash_rsp.bucket;
                    if (r_op == tsft_pkg::OP_IGNORE) begin
                        n_state = tsft_pkg::S_UPD;
                    end else begin
                        n_state = tsft_pkg::S_BASE;
                    end
                end
            end
            tsft_pkg::S_BASE: begin
                n_base  = AW'(r_bucket * tsft_pkg::WAYS);
                n_state = tsft_pkg::S_RD;
            end
            tsft_pkg::S_RD: begin
                // read of base + way lands in r_rd at the next edge
                n_state = tsft_pkg::S_CMP;
            end
            tsft_pkg::S_CMP: begin
                if (hit_fwd || hit_rev) begin
                    n_found   = 1'b1;
                    n_dir     = hit_fwd ? tsft_pkg::DIR_SAME : tsft_pkg::DIR_REV;
                    n_hit_way = r_way;
                    n_time    = r_rd.stamp;
                    n_state   = tsft_pkg::S_UPD;
                end else begin
                    if (!r_rd.valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_way   = r_way;
                    end
                    if (r_way == WW'(tsft_pkg::WAYS - 1)) begin
                        n_state = tsft_pkg::S_UPD;
                    end else begin
                        n_way   = r_way + 1'b1;
                        n_state = tsft_pkg::S_RD;
                    end
                end
            end
            tsft_pkg::S_UPD: begin
                mem_addr = r_base + AW'(wr_way);
                unique case (r_op)
                    tsft_pkg::OP_INSERT: begin
                        if (r_found) begin
                            n_res_status = tsft_pkg::ST_TRACKED;
                        end else if (r_free_found) begin
                            mem_we          = 1'b1;
                            mem_wdata.valid = 1'b1;
                            mem_wdata.addrs = {r_sa, r_da};
                            mem_wdata.ports = {r_sp, r_dp};
                            mem_wdata.stamp = r_tm;
                            n_res_status    = tsft_pkg::ST_STORED;
                        end else begin
                            if (r_refused != '1) begin
                                n_refused = r_refused + 1'b1;
                            end
                            n_res_status = tsft_pkg::ST_FULL;
                        end
                    end
                    tsft_pkg::OP_REMOVE: begin
                        if (r_found) begin
                            // drop the entry: write it back all zero
                            mem_we       = 1'b1;
                            n_res_status = tsft_pkg::ST_REMOVED;
                        end else begin
                            n_res_status = tsft_pkg::ST_UNTRACKED;
                        end
                    end
                    default: begin
                        n_res_status = tsft_pkg::ST_IGNORED;
                    end
                endcase
                n_state = tsft_pkg::S_DONE;
            end
            tsft_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_dir     = r_dir;
                    n_o_time    = r_time;
                    n_o_bucket  = 10'(r_bucket);
                    n_o_refused = r_refused;
                    n_state     = tsft_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsft_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_direction     = r_o_dir;
    assign o_stored_time   = r_o_time;
    assign o_bucket        = r_o_bucket;
    assign o_refused_total = r_o_refused;

    // no packet enters while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsft_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("input accepted during clearing pass");

    // the table is written only by the clearing pass or the update step
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == tsft_pkg::S_CLEAR || r_state == tsft_pkg::S_UPD))
        else $error("entry write outside clear or update");

    // refused counter never goes back
    a_refused_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_refused >= $past(r_refused)))
        else $error("refused counter decreased");

    // results without a matched flow carry no direction and no time
    a_nomatch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != tsft_pkg::ST_TRACKED
                   && r_o_status != tsft_pkg::ST_REMOVED)
        |-> (r_o_dir == tsft_pkg::DIR_NONE && r_o_time == '0))
        else $error("unmatched result carries match data");

    // a beat appears on the output only out of the final step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == tsft_pkg::S_DONE))
        else $error("output beat not from final step");

endmodule

@@ test/tcp_syn_flow_table_unit_test.sv @@
`timescale 1ns / 100ps

module tcp_syn_flow_table_unit_test;

    // One TCP flow as seen from the packet: addresses and ports in packet order.
    typedef struct {
        bit [31:0] src_addr;
        bit [31:0] dst_addr;
        bit [15:0] source_port;
        bit [15:0] dst_port;
    } t_flow;

    // What the block must answer for one packet.
    typedef struct {
        tsft_pkg::t_status status;
        tsft_pkg::t_dir    direction;
        bit [31:0]         stored_time;
        bit [9:0]          bucket;
        bit [31:0]         refused_total;
    } t_flow_verdict;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned HOT_BUCKETS  = 8;
    localparam int unsigned FLOWS_PER_HOT = 6;
    localparam int unsigned POOL_SIZE    = HOT_BUCKETS * FLOWS_PER_HOT;
    localparam int unsigned DRAIN_CYCLES = 2 * tsft_pkg::WAYS + 12;

    localparam bit [7:0] F_SYN = 8'(1) << tsft_pkg::FLAG_SYN;
    localparam bit [7:0] F_RST = 8'(1) << tsft_pkg::FLAG_RST;
    localparam bit [7:0] F_ACK = 8'(1) << tsft_pkg::FLAG_ACK;
    // flag bits the block never looks at
    localparam bit [7:0] F_NOISE = ~(F_SYN | F_RST | F_ACK);

    // Shadow of the flow table: predicts every result beat and checks it in order.
    class flow_tracker;
        bit            slot_valid [tsft_pkg::DEPTH];
        bit [63:0]     slot_addrs [tsft_pkg::DEPTH];
        bit [31:0]     slot_ports [tsft_pkg::DEPTH];
        bit [31:0]     slot_stamp [tsft_pkg::DEPTH];
        bit [31:0]     refused;
        t_flow_verdict verdict_q [$];
        int unsigned   errors;

        // Scan the ways from the lowest; same direction wins over reverse within a way.
        function int find_way(bit [31:0] base, bit [63:0] fa, bit [31:0] fp,
                              bit [63:0] ra, bit [31:0] rp, output tsft_pkg::t_dir d);
            int w;
            d = tsft_pkg::DIR_NONE;
            for (w = 0; w < tsft_pkg::WAYS; w++) begin
                if (slot_valid[base + w]) begin
                    if (slot_addrs[base + w] == fa && slot_ports[base + w] == fp) begin
                        d = tsft_pkg::DIR_SAME;
                        return w;
                    end
                    if (slot_addrs[base + w] == ra && slot_ports[base + w] == rp) begin
                        d = tsft_pkg::DIR_REV;
                        return w;
                    end
                end
            end
            return -1;
        endfunction

        function void note_packet(bit [31:0] sa, bit [31:0] da, bit [15:0] sp,
                                  bit [15:0] dp, bit [7:0] fl, bit [31:0] tm);
            bit [31:0]      sum;
            bit [31:0]      nbkt;
            bit [31:0]      bkt;
            bit [31:0]      base;
            bit [63:0]      fa;
            bit [63:0]      ra;
            bit [31:0]      fp;
            bit [31:0]      rp;
            bit             syn;
            bit             ack;
            bit             rst;
            int             w;
            int             f;
            int             k;
            tsft_pkg::t_dir d;
            t_flow_verdict  v;

            sum  = sa + da + 32'(sp) + 32'(dp);
            nbkt = tsft_pkg::BUCKETS;
            bkt  = sum % nbkt;
            base = bkt * tsft_pkg::WAYS;
            fa   = {sa, da};
            ra   = {da, sa};
            fp   = {sp, dp};
            rp   = {dp, sp};
            syn  = fl[tsft_pkg::FLAG_SYN];
            ack  = fl[tsft_pkg::FLAG_ACK];
            rst  = fl[tsft_pkg::FLAG_RST];

            v.status      = tsft_pkg::ST_IGNORED;
            v.direction   = tsft_pkg::DIR_NONE;
            v.stored_time = '0;
            v.bucket      = bkt[9:0];

            if (syn && !ack) begin
                // SYN, even with RST set: report a known flow, store a new one, or refuse it when full
                w = find_way(base, fa, fp, ra, rp, d);
                if (w >= 0) begin
                    v.status      = tsft_pkg::ST_TRACKED;
                    v.direction   = d;
                    v.stored_time = slot_stamp[base + w];
                end else begin
                    f = -1;
                    for (k = 0; k < tsft_pkg::WAYS; k++) begin
                        if (f < 0 && !slot_valid[base + k]) f = k;
                    end
                    if (f >= 0) begin
                        slot_valid[base + f] = 1'b1;
                        slot_addrs[base + f] = fa;
                        slot_ports[base + f] = fp;
                        slot_stamp[base + f] = tm;
                        v.status = tsft_pkg::ST_STORED;
                    end else begin
                        if (refused != '1) refused++;
                        v.status = tsft_pkg::ST_FULL;
                    end
                end
            end else if (syn || rst) begin
                // SYN+ACK or RST: drop the whole matching flow
                w = find_way(base, fa, fp, ra, rp, d);
                if (w >= 0) begin
                    v.status      = tsft_pkg::ST_REMOVED;
                    v.direction   = d;
                    v.stored_time = slot_stamp[base + w];
                    slot_valid[base + w] = 1'b0;
                    slot_addrs[base + w] = '0;
                    slot_ports[base + w] = '0;
                    slot_stamp[base + w] = '0;
                end else begin
                    v.status = tsft_pkg::ST_UNTRACKED;
                end
            end

            v.refused_total = refused;
            verdict_q.push_back(v);
        endfunction

        function void compare_field(string label, bit [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", label, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] st, logic [1:0] dir, logic [31:0] stime,
                                   logic [9:0] bkt, logic [31:0] total);
            t_flow_verdict v;
            if (verdict_q.size() == 0) begin
                $error("result beat with no packet waiting for it");
                errors++;
                return;
            end
            v = verdict_q.pop_front();
            compare_field("status", 32'(v.status), 32'(st));
            compare_field("direction", 32'(v.direction), 32'(dir));
            compare_field("stored_time", v.stored_time, stime);
            compare_field("bucket", 32'(v.bucket), 32'(bkt));
            compare_field("refused_total", v.refused_total, total);
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [15:0] i_source_port;
    logic [15:0] i_dst_port;
    logic [7:0]  i_tcp_flags;
    logic [31:0] i_arrival_time;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [1:0]  o_direction;
    logic [31:0] o_stored_time;
    logic [9:0]  o_bucket;
    logic [31:0] o_refused_total;

    tcp_syn_flow_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_src_addr      (i_src_addr),
        .i_dst_addr      (i_dst_addr),
        .i_source_port   (i_source_port),
        .i_dst_port      (i_dst_port),
        .i_tcp_flags     (i_tcp_flags),
        .i_arrival_time  (i_arrival_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_direction     (o_direction),
        .o_stored_time   (o_stored_time),
        .o_bucket        (o_bucket),
        .o_refused_total (o_refused_total)
    );

    flow_tracker tracker;
    int unsigned cycle_count;
    int unsigned burst_left;

    // receiver stall pattern state
    int unsigned rx_mode;
    int unsigned rx_span;
    int unsigned rx_run;
    bit          rx_level;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bail out if the block hangs; the limit is far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tcp_syn_flow_table_unit: mismatch");
            $finish;
        end
    end

    // Receiver: switch between always ready, coin-flip ready and long stall runs.
    always @(negedge i_clk) begin
        logic ready_next;
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(100, 400);
        end
        rx_span--;
        case (rx_mode)
            0: begin
                ready_next = 1'b1;
            end
            1: begin
                ready_next = 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_run == 0) begin
                    rx_level = !rx_level;
                    rx_run   = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 15);
                end
                rx_run--;
                ready_next = rx_level;
            end
        endcase
        i_out_ready <= ready_next;
    end

    // Check every result beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            tracker.check_result(o_status, o_direction, o_stored_time, o_bucket,
                                 o_refused_total);
        end
    end

    // Build a random flow that hashes into the given bucket (low 10 bits of the sum).
    function automatic t_flow make_flow(bit [9:0] bkt);
        t_flow     f;
        bit [31:0] part;
        f.src_addr    = $urandom;
        f.dst_addr    = $urandom;
        f.source_port = 16'($urandom_range(0, 65535));
        f.dst_port    = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0: f.src_addr = '0;
            1: f.dst_addr = '1;
            default: ;
        endcase
        part = f.src_addr + f.dst_addr + 32'(f.source_port);
        f.dst_port[9:0] = bkt - part[9:0];
        return f;
    endfunction

    function automatic t_flow reverse_flow(t_flow f);
        t_flow r;
        r.src_addr    = f.dst_addr;
        r.dst_addr    = f.src_addr;
        r.source_port = f.dst_port;
        r.dst_port    = f.source_port;
        return r;
    endfunction

    // Drive one packet beat, idling between bursts, and note it once accepted.
    task automatic send_packet(t_flow f, bit [7:0] flags, bit [31:0] stamp);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_src_addr     <= f.src_addr;
        i_dst_addr     <= f.dst_addr;
        i_source_port  <= f.source_port;
        i_dst_port     <= f.dst_port;
        i_tcp_flags    <= flags;
        i_arrival_time <= stamp;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_packet(f.src_addr, f.dst_addr, f.source_port, f.dst_port, flags, stamp);
    endtask

    initial begin
        t_flow       fz;
        t_flow       fo;
        t_flow       fb [5];
        t_flow       fn;
        t_flow       pool [POOL_SIZE];
        t_flow       f;
        bit [9:0]    hot [HOT_BUCKETS];
        bit [7:0]    flags;
        int unsigned counted;
        int unsigned roll;
        int unsigned idx;
        int          i;

        tracker        = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_src_addr     = '0;
        i_dst_addr     = '0;
        i_source_port  = '0;
        i_dst_port     = '0;
        i_tcp_flags    = '0;
        i_arrival_time = '0;
        i_out_ready    = 1'b0;
        burst_left     = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. All-zero and all-one flows are their own reverse.
        fz = '{32'h0, 32'h0, 16'h0, 16'h0};
        fo = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
        for (i = 0; i < 5; i++) fb[i] = make_flow(10'd5);
        fn = make_flow(10'd5);

        send_packet(fz, F_SYN, 32'h0);                          // store in bucket zero
        send_packet(fz, F_SYN, 32'd7);                          // already tracked, same way
        send_packet(fo, F_SYN | F_NOISE, 32'hFFFF_FFFF);        // unused flag bits set
        send_packet(fo, F_RST | F_ACK, 32'h0);                  // remove top-time entry
        for (i = 0; i < 4; i++) send_packet(fb[i], F_SYN, $urandom);  // fill bucket
        send_packet(reverse_flow(fb[1]), F_SYN, $urandom);      // tracked in reverse
        send_packet(fb[4], F_SYN | F_RST, $urandom);            // SYN with RST, bucket full
        send_packet(fb[4], F_SYN, $urandom);                    // refused again
        send_packet(reverse_flow(fb[2]), F_RST, $urandom);      // remove in reverse
        send_packet(fn, F_SYN | F_ACK, $urandom);               // same bucket, other flow
        send_packet(fb[4], F_SYN | F_RST, 32'hFFFF_FFFF);       // takes the freed way
        send_packet(fb[0], 8'hFF, $urandom);                    // every flag set: removal
        send_packet(fb[0], F_ACK, $urandom);                    // plain ACK: ignored
        send_packet(fb[0], 8'h00, $urandom);                    // no flags: ignored
        send_packet(fb[0], F_NOISE, $urandom);                  // unused bits only
        send_packet(fz, F_SYN | F_ACK, $urandom);               // remove zero flow
        send_packet(fz, F_RST, $urandom);                       // now untracked
        send_packet(fb[3], F_SYN | F_ACK | F_RST, $urandom);    // removal with both

        // Random part: a pool of flows crowded into a few buckets drives the table
        // through store, hit, remove and full; a share of raw noise goes in as well.
        hot[0] = 10'd0;
        hot[1] = 10'd1023;
        for (i = 2; i < HOT_BUCKETS; i++) hot[i] = 10'($urandom_range(0, 1023));
        for (i = 0; i < POOL_SIZE; i++) pool[i] = make_flow(hot[i / FLOWS_PER_HOT]);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 49) == 0) begin
                idx       = $urandom_range(0, POOL_SIZE - 1);
                pool[idx] = make_flow(hot[idx / FLOWS_PER_HOT]);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                f.src_addr    = $urandom;
                f.dst_addr    = $urandom;
                f.source_port = 16'($urandom_range(0, 65535));
                f.dst_port    = 16'($urandom_range(0, 65535));
                flags         = 8'($urandom_range(0, 255));
            end else begin
                f = pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 3) == 0) f = reverse_flow(f);
                flags = 8'($urandom) & F_NOISE;
                roll  = $urandom_range(0, 99);
                if (roll < 45) begin
                    flags |= F_SYN;
                    if ($urandom_range(0, 3) == 0) flags |= F_RST;
                end else if (roll < 65) begin
                    flags |= F_SYN | F_ACK;
                    if ($urandom_range(0, 3) == 0) flags |= F_RST;
                end else if (roll < 85) begin
                    flags |= F_RST;
                    if ($urandom_range(0, 1) == 0) flags |= F_ACK;
                end else if ($urandom_range(0, 1) == 0) begin
                    flags |= F_ACK;
                end
            end
            send_packet(f, flags, $urandom);
            counted++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain: wait for every predicted beat, then a little longer for strays.
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0) begin
            $display("tcp_syn_flow_table_unit: match");
        end else begin
            $display("tcp_syn_flow_table_unit: mismatch");
        end
        $finish;
    end

endmodule
